### rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types, constants and elaboration helpers for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int ORDER_LIMIT   = 10;
  localparam int TOP_ORDER_DEF = ORDER_LIMIT;

  localparam int OP_W   = 2;
  localparam int PAGE_W = 10;
  localparam int ORD_W  = 4;
  localparam int CNT_W  = 11;

  // The free map is stored as rows of ROW_W bits; each order starts on a new row.
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;
  // Width used for order arithmetic (orders never exceed 20).
  localparam int LOG_W  = 5;

  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR_ROW,
    WR_SET,
    WR_TAKE,
    WR_MERGE,
    WR_SET_ODD
  } wr_mode_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_FAIL,
    RES_ALLOC,
    RES_FREE
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd;
    wr_mode_t wr;
    logic     take;
    logic     next_row;
    logic     next_order;
    logic     split;
    logic     merge_up;
    logic     ins_set;
    logic     ins_adv;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ord_bad;
    logic            cnt_zero;
    logic            clr_last;
    logic            row_nz;
    logic            row_last;
    logic            k_top;
    logic            k_above_ord;
    logic            buddy_free;
    logic            ins_done;
  } dp_stat_t;

  // Number of map rows that order k occupies in a space of 2^top pages.
  function automatic int rows_in_order(input int top, input int k);
    return ((1 << (top - k)) + ROW_W - 1) >> ROW_BW;
  endfunction

  // First row of order k; with k = top + 1 this is the total row count.
  function automatic int row_base(input int top, input int k);
    int acc;
    acc = 0;
    for (int j = 0; j < k; j++) begin
      acc = acc + rows_in_order(top, j);
    end
    return acc;
  endfunction

endpackage

### rtl/bpa_dpath.sv
// ----------------------------------------------------------------------------
// bpa_dpath
// Free map memory, walk registers and result registers of the allocator.
// ----------------------------------------------------------------------------
module bpa_dpath import bpa_pkg::*; #(
  parameter int TOP_ORDER = TOP_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [OP_W-1:0]   in_op,
  input  logic [PAGE_W-1:0] in_page_number,
  input  logic [ORD_W-1:0]  in_size_order,
  input  logic [CNT_W-1:0]  in_page_count,
  output logic              out_status,
  output logic [PAGE_W-1:0] out_result_page,
  output logic [ORD_W-1:0]  out_result_order
);

  localparam int PW   = TOP_ORDER;
  localparam int KW   = $clog2(TOP_ORDER + 1);
  localparam int IXW  = TOP_ORDER + ROW_BW;
  localparam int ROWS = row_base(TOP_ORDER, TOP_ORDER + 1);
  localparam int RAW  = $clog2(ROWS);
  localparam logic [IXW:0] NPAGES_V = (IXW+1)'(1) << TOP_ORDER;

  logic [ROW_W-1:0]  mem [ROWS];
  logic [ROW_W-1:0]  rdata_r;
  logic [RAW-1:0]    base_tbl [TOP_ORDER+1];

  logic [OP_W-1:0]   op_r;
  logic [ORD_W-1:0]  ord_r;
  logic [KW-1:0]     k_r;
  logic [IXW-1:0]    idx_r;
  logic [PW:0]       start_r;
  logic [CNT_W-1:0]  rem_r;
  logic [LOG_W-1:0]  target_r;
  logic [RAW-1:0]    clr_cnt_r;

  logic              status_r;
  logic [PAGE_W-1:0] page_out_r;
  logic [ORD_W-1:0]  ord_out_r;

  for (genvar g = 0; g <= TOP_ORDER; g++) begin : g_base
    assign base_tbl[g] = RAW'(row_base(TOP_ORDER, g));
  end

  logic [PW-1:0]      page_m;
  logic [IXW:0]       cnt_k;
  logic [IXW-1:0]     idx_m;
  logic [RAW-1:0]     addr;
  logic [ROW_BW-1:0]  bpos;
  logic [ROW_BW-1:0]  ffs;
  logic [LOG_W-1:0]   lg_cnt;
  logic [LOG_W-1:0]   lg_rem;
  logic [LOG_W-1:0]   ctz;
  logic [LOG_W-1:0]   ins_i;
  logic [LOG_W-1:0]   tgt_in;
  logic [ROW_W-1:0]   wdata;
  logic [RAW-1:0]     waddr;
  logic [PW-1:0]      pg_alloc;
  logic [PW-1:0]      pg_free;

  always_comb begin
    page_m = PW'(in_page_number);
    cnt_k  = NPAGES_V >> k_r;
    idx_m  = idx_r & IXW'(cnt_k - (IXW+1)'(1));
    addr   = base_tbl[k_r] + RAW'(idx_m >> ROW_BW);
    bpos   = idx_m[ROW_BW-1:0];

    // Lowest set bit of the row just read.
    ffs = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (rdata_r[j]) begin
        ffs = ROW_BW'(j);
      end
    end

    lg_cnt = '0;
    lg_rem = '0;
    for (int j = 0; j < CNT_W; j++) begin
      if (in_page_count[j]) begin
        lg_cnt = LOG_W'(j);
      end
      if (rem_r[j]) begin
        lg_rem = LOG_W'(j);
      end
    end
    tgt_in = (lg_cnt > LOG_W'(TOP_ORDER)) ? LOG_W'(TOP_ORDER) : lg_cnt;

    // Alignment of the insert cursor; zero counts as fully aligned.
    ctz = LOG_W'(TOP_ORDER);
    for (int j = PW - 1; j >= 0; j--) begin
      if (start_r[j]) begin
        ctz = LOG_W'(j);
      end
    end

    ins_i = (target_r < lg_rem) ? target_r : lg_rem;
    if (ctz < ins_i) begin
      ins_i = ctz;
    end

    waddr = addr;
    wdata = rdata_r;
    unique case (cmd.wr)
      WR_CLR_ROW: begin
        waddr = clr_cnt_r;
        wdata = '0;
      end
      WR_SET:     wdata = rdata_r | (ROW_W'(1) << bpos);
      WR_TAKE:    wdata = rdata_r & ~(ROW_W'(1) << ffs);
      WR_MERGE:   wdata = rdata_r & ~(ROW_W'(1) << bpos) & ~(ROW_W'(1) << (bpos ^ ROW_BW'(1)));
      WR_SET_ODD: wdata = rdata_r | (ROW_W'(1) << (bpos | ROW_BW'(1)));
      default:    wdata = rdata_r;
    endcase

    pg_alloc = PW'(idx_r << ord_r);
    pg_free  = PW'(idx_r << k_r);
  end

  always_comb begin
    stat.op          = op_r;
    stat.ord_bad     = LOG_W'(ord_r) > LOG_W'(TOP_ORDER);
    stat.cnt_zero    = (rem_r == '0);
    stat.clr_last    = (clr_cnt_r == RAW'(ROWS - 1));
    stat.row_nz      = |rdata_r;
    stat.row_last    = ((IXW+1)'(idx_r) + (IXW+1)'(ROW_W)) >= cnt_k;
    stat.k_top       = (k_r == KW'(TOP_ORDER));
    stat.k_above_ord = LOG_W'(k_r) > LOG_W'(ord_r);
    stat.buddy_free  = rdata_r[bpos ^ ROW_BW'(1)];
    stat.ins_done    = (rem_r == '0) || start_r[PW];
  end

  // Map memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr != WR_NONE) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.wr == WR_CLR_ROW) begin
      clr_cnt_r <= clr_cnt_r + RAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      ord_r    <= in_size_order;
      k_r      <= KW'(in_size_order);
      idx_r    <= (in_op == OP_FREE) ? IXW'(page_m >> in_size_order) : '0;
      start_r  <= {1'b0, page_m};
      rem_r    <= in_page_count;
      target_r <= tgt_in;
    end
    if (cmd.take) begin
      idx_r <= idx_r + IXW'(ffs);
    end
    if (cmd.next_row) begin
      idx_r <= idx_r + IXW'(ROW_W);
    end
    if (cmd.next_order) begin
      k_r   <= k_r + KW'(1);
      idx_r <= '0;
    end
    if (cmd.split) begin
      k_r   <= k_r - KW'(1);
      idx_r <= idx_r << 1;
    end
    if (cmd.merge_up) begin
      k_r   <= k_r + KW'(1);
      idx_r <= idx_m >> 1;
    end
    if (cmd.ins_set) begin
      k_r   <= KW'(ins_i);
      idx_r <= IXW'(start_r >> ins_i);
    end
    if (cmd.ins_adv) begin
      start_r <= start_r + ((PW+1)'(1) << k_r);
      rem_r   <= rem_r - (CNT_W'(1) << k_r);
    end
    if (cmd.out_load) begin
      unique case (cmd.res_sel)
        RES_FAIL: begin
          status_r   <= 1'b1;
          page_out_r <= '0;
          ord_out_r  <= '0;
        end
        RES_ALLOC: begin
          status_r   <= 1'b0;
          page_out_r <= PAGE_W'(pg_alloc);
          ord_out_r  <= ord_r;
        end
        RES_FREE: begin
          status_r   <= 1'b0;
          page_out_r <= PAGE_W'(pg_free);
          ord_out_r  <= ORD_W'(k_r);
        end
        default: begin
          status_r   <= 1'b0;
          page_out_r <= '0;
          ord_out_r  <= '0;
        end
      endcase
    end
  end

  assign out_status       = status_r;
  assign out_result_page  = page_out_r;
  assign out_result_order = ord_out_r;

endmodule

### rtl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for clearing, search, split, merge and range insert.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_ASRD  = 4'd3;
  localparam logic [3:0] S_ASCHK = 4'd4;
  localparam logic [3:0] S_SPCHK = 4'd5;
  localparam logic [3:0] S_SPRD  = 4'd6;
  localparam logic [3:0] S_SPWR  = 4'd7;
  localparam logic [3:0] S_FRD   = 4'd8;
  localparam logic [3:0] S_FCHK  = 4'd9;
  localparam logic [3:0] S_INS   = 4'd10;
  localparam logic [3:0] S_INRD  = 4'd11;
  localparam logic [3:0] S_INWR  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state_r, state_nxt;
  res_sel_t   res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_CLR: begin
        cmd.wr = WR_CLR_ROW;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          OP_ALLOC: begin
            if (stat.ord_bad) begin
              res_nxt   = RES_FAIL;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_ASRD;
            end
          end
          OP_FREE: begin
            if (stat.ord_bad) begin
              res_nxt   = RES_FAIL;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_FRD;
            end
          end
          OP_INSERT: begin
            res_nxt   = RES_ZERO;
            state_nxt = stat.cnt_zero ? S_FIN : S_INS;
          end
          default: begin
            res_nxt   = RES_ZERO;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_ASRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_ASCHK;
      end
      S_ASCHK: begin
        if (stat.row_nz) begin
          cmd.wr    = WR_TAKE;
          cmd.take  = 1'b1;
          state_nxt = S_SPCHK;
        end else if (stat.row_last) begin
          if (stat.k_top) begin
            res_nxt   = RES_FAIL;
            state_nxt = S_FIN;
          end else begin
            cmd.next_order = 1'b1;
            state_nxt      = S_ASRD;
          end
        end else begin
          cmd.next_row = 1'b1;
          state_nxt    = S_ASRD;
        end
      end
      S_SPCHK: begin
        if (stat.k_above_ord) begin
          cmd.split = 1'b1;
          state_nxt = S_SPRD;
        end else begin
          res_nxt   = RES_ALLOC;
          state_nxt = S_FIN;
        end
      end
      S_SPRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SPWR;
      end
      S_SPWR: begin
        cmd.wr    = WR_SET_ODD;
        state_nxt = S_SPCHK;
      end
      S_FRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (!stat.k_top && stat.buddy_free) begin
          cmd.wr       = WR_MERGE;
          cmd.merge_up = 1'b1;
          state_nxt    = S_FRD;
        end else begin
          cmd.wr    = WR_SET;
          res_nxt   = RES_FREE;
          state_nxt = S_FIN;
        end
      end
      S_INS: begin
        if (stat.ins_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.ins_set = 1'b1;
          state_nxt   = S_INRD;
        end
      end
      S_INRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_INWR;
      end
      S_INWR: begin
        cmd.wr      = WR_SET;
        cmd.ins_adv = 1'b1;
        state_nxt   = S_INS;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    cmd.res_sel   = res_r;
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      res_r       <= RES_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("accepted item not dispatched");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cmd.wr == WR_NONE))
    else $error("map written while idle");

endmodule

### rtl/buddy_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Binary buddy page allocator with one free map per order, held in a row memory.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   op, page_number, size_order, page_count
//   out_     output     out_valid / out_ready status, result_page, result_order
//
// Every accepted item produces exactly one result item.
// After reset a clearing pass writes every map row to zero, one row per cycle;
// no item is accepted until it ends. An allocate scans map rows from its own order
// upward and then splits the block it takes down to the asked order; a failed one
// scans every row up to the top order. Free climbs orders while the buddy is free;
// insert writes one aligned block per step; a bad order fails without a map access.
// The unit returns to idle before the next item can be accepted.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted, and that item stalls only at its own finish.

module buddy_page_allocator_unit import bpa_pkg::*; #(
  parameter int TOP_ORDER = TOP_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [PAGE_W-1:0] in_page_number,
  input  logic [ORD_W-1:0]  in_size_order,
  input  logic [CNT_W-1:0]  in_page_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic [PAGE_W-1:0] out_result_page,
  output logic [ORD_W-1:0]  out_result_order
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences each operation one map row access at a time.
  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the map memory, the walk cursor and the result register.
  bpa_dpath #(
    .TOP_ORDER (TOP_ORDER)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_op),
    .in_page_number   (in_page_number),
    .in_size_order    (in_size_order),
    .in_page_count    (in_page_count),
    .out_status       (out_status),
    .out_result_page  (out_result_page),
    .out_result_order (out_result_order)
  );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buddy page allocator. A directed table and then
// random item streams are driven through the input channel; a behavioral model
// of the free maps predicts each result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import bpa_pkg::*;

  localparam int TOP      = ORDER_LIMIT;
  localparam int NPG      = 1 << TOP;
  localparam int MAPB     = 2 << TOP;
  localparam int WDOG_MAX = 20000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   in_op;
  logic [PAGE_W-1:0] in_page_number;
  logic [ORD_W-1:0]  in_size_order;
  logic [CNT_W-1:0]  in_page_count;
  logic              out_valid;
  logic              out_ready;
  logic              out_status;
  logic [PAGE_W-1:0] out_result_page;
  logic [ORD_W-1:0]  out_result_order;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] page;
    logic [ORD_W-1:0]  order;
  } alloc_res_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [PAGE_W-1:0] page;
    logic [ORD_W-1:0]  order;
    logic [CNT_W-1:0]  count;
    logic              fixed;
    alloc_res_t        res;
  } dir_row_t;

  buddy_page_allocator_unit dut (.*);

  // Model state: one bit per block of every order.
  bit         free_bits [MAPB];
  alloc_res_t pending_results [$];
  alloc_res_t typed_results [$];
  logic       typed_valid [$];
  int         errors;
  int         send_idle_pct;
  int         recv_idle_pct;
  bit         hold_off;
  bit         stim_done;
  int         wdog;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int bit_idx(int k, int i);
    return MAPB - (MAPB >> k) + (i & ((NPG >> k) - 1));
  endfunction

  // Applies one item to the model maps and returns the result it causes.
  function automatic alloc_res_t buddy_apply(logic [OP_W-1:0] op, int pg, int ord,
                                             int cnt);
    alloc_res_t r;
    int k, idx, tgt, t, st, rem, i;
    bit found;
    r = '0;
    found = 0;
    idx = 0;
    pg = pg & (NPG - 1);
    if (op == OP_ALLOC) begin
      if (ord <= TOP) begin
        for (k = ord; k <= TOP && !found; k++) begin
          for (idx = 0; idx < (NPG >> k); idx++)
            if (free_bits[bit_idx(k, idx)]) begin
              found = 1;
              break;
            end
          if (found) break;
        end
      end
      if (!found) begin
        r.status = 1'b1;
      end else begin
        free_bits[bit_idx(k, idx)] = 0;
        while (k > ord) begin
          k--;
          idx = idx << 1;
          free_bits[bit_idx(k, idx + 1)] = 1;
        end
        r.page  = PAGE_W'(idx << ord);
        r.order = ORD_W'(ord);
      end
    end else if (op == OP_FREE) begin
      if (ord > TOP) begin
        r.status = 1'b1;
      end else begin
        k = ord;
        idx = pg >> ord;
        free_bits[bit_idx(k, idx)] = 1;
        while (k < TOP && free_bits[bit_idx(k, idx ^ 1)]) begin
          free_bits[bit_idx(k, idx)] = 0;
          free_bits[bit_idx(k, idx ^ 1)] = 0;
          idx = idx >> 1;
          k++;
          free_bits[bit_idx(k, idx)] = 1;
        end
        r.page  = PAGE_W'(idx << k);
        r.order = ORD_W'(k);
      end
    end else if (op == OP_INSERT && cnt > 0) begin
      tgt = 0;
      t = cnt;
      while (t > 1) begin
        t = t >> 1;
        tgt++;
      end
      if (tgt > TOP) tgt = TOP;
      st = pg;
      rem = cnt;
      while (rem > 0 && st < NPG) begin
        i = tgt;
        while (i > 0 && (((st & ((1 << i) - 1)) != 0) || (1 << i) > rem)) i--;
        free_bits[bit_idx(i, st >> i)] = 1;
        st += 1 << i;
        rem -= 1 << i;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
    errors++;
  endtask

  // Drives one item and waits for its acceptance. The expected result is
  // queued at the accepting edge so it is always ahead of the result. Valid
  // stays high into the next item unless the sender idles.
  task automatic send_item(logic [OP_W-1:0] op, int pg, int ord, int cnt,
                           logic fixed, alloc_res_t res);
    alloc_res_t pr;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_page_number <= PAGE_W'(pg);
    in_size_order  <= ORD_W'(ord);
    in_page_count  <= CNT_W'(cnt);
    do @(posedge clk); while (!in_ready);
    pr = buddy_apply(op, pg, ord, cnt);
    pending_results.push_back(pr);
    typed_valid.push_back(fixed);
    typed_results.push_back(res);
    @(negedge clk);
  endtask

  // Result side: compare against the predictor, and against the typed value
  // where the table gives one.
  always @(posedge clk) begin
    alloc_res_t e, tr;
    logic tv;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        e  = pending_results.pop_front();
        tv = typed_valid.pop_front();
        tr = typed_results.pop_front();
        if (tv) e = tr;
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_result_page !== e.page)
          report_mismatch("result_page", out_result_page, e.page);
        if (out_result_order !== e.order)
          report_mismatch("result_order", out_result_order, e.order);
      end
    end
  end

  // Receiver readiness, changed at the falling edge.
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no accepted item in either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Long receiver hold-off, counted here, while the sender keeps offering.
  initial begin
    hold_off = 1'b0;
    wait (stim_done == 1'b0 && rst_n);
    repeat (400) @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  task automatic random_item();
    int sel, ord;
    sel = $urandom_range(99);
    ord = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(TOP);
    if (sel < 40) begin
      send_item(OP_ALLOC, $urandom_range(NPG - 1), ($urandom_range(3) == 0) ? ord
                : $urandom_range(3), 0, 1'b0, '0);
    end else if (sel < 75) begin
      send_item(OP_FREE, $urandom_range(NPG - 1), ($urandom_range(3) == 0) ? ord
                : $urandom_range(3), $urandom_range(2047), 1'b0, '0);
    end else if (sel < 95) begin
      send_item(OP_INSERT, $urandom_range(NPG - 1), $urandom_range(15),
                ($urandom_range(4) == 0) ? $urandom_range(2047) : $urandom_range(64),
                1'b0, '0);
    end else begin
      send_item(2'd3, $urandom_range(NPG - 1), $urandom_range(15),
                $urandom_range(2047), 1'b0, '0);
    end
  endtask

  initial begin
    dir_row_t dir_rows [$];
    alloc_res_t fail_res;
    alloc_res_t zero_res;
    int n;
    fail_res = '{status: 1'b1, page: '0, order: '0};
    zero_res = '0;
    errors = 0;
    stim_done = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 57;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_ALLOC;
    in_page_number = '0;
    in_size_order = '0;
    in_page_count = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed table: empty-map failures, the whole space, extremes and
    // each named corner case.
    dir_rows = '{
      '{OP_ALLOC,  10'd0,    4'd0,  11'd0,    1'b1, fail_res},
      '{OP_ALLOC,  10'd0,    4'd15, 11'd0,    1'b1, fail_res},
      '{OP_INSERT, 10'd0,    4'd0,  11'd0,    1'b1, zero_res},
      '{OP_INSERT, 10'd0,    4'd0,  11'd1024, 1'b1, zero_res},
      '{OP_ALLOC,  10'd1023, 4'd10, 11'd0,    1'b1, '{1'b0, 10'd0, 4'd10}},
      '{OP_ALLOC,  10'd0,    4'd0,  11'd0,    1'b1, fail_res},
      '{OP_FREE,   10'd1023, 4'd10, 11'd0,    1'b1, '{1'b0, 10'd0, 4'd10}},
      '{OP_ALLOC,  10'd0,    4'd0,  11'd0,    1'b1, '{1'b0, 10'd0, 4'd0}},
      '{OP_ALLOC,  10'd0,    4'd0,  11'd0,    1'b0, zero_res},
      '{OP_FREE,   10'd0,    4'd11, 11'd0,    1'b1, fail_res},
      '{OP_ALLOC,  10'd0,    4'd15, 11'd0,    1'b1, fail_res},
      '{OP_FREE,   10'd1,    4'd0,  11'd0,    1'b0, zero_res},
      '{OP_FREE,   10'd1,    4'd0,  11'd0,    1'b0, zero_res},
      '{OP_FREE,   10'd3,    4'd1,  11'd0,    1'b0, zero_res},
      '{2'd3,      10'd1023, 4'd15, 11'd2047, 1'b1, zero_res},
      '{OP_INSERT, 10'd1000, 4'd0,  11'd2047, 1'b1, zero_res},
      '{OP_INSERT, 10'd5,    4'd0,  11'd37,   1'b1, zero_res},
      '{OP_ALLOC,  10'd0,    4'd3,  11'd0,    1'b0, zero_res},
      '{OP_FREE,   10'd1022, 4'd10, 11'd0,    1'b0, zero_res},
      '{OP_ALLOC,  10'd0,    4'd10, 11'd0,    1'b0, zero_res},
      '{OP_ALLOC,  10'd0,    4'd9,  11'd0,    1'b0, zero_res}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].page, dir_rows[i].order,
                dir_rows[i].count, dir_rows[i].fixed, dir_rows[i].res);

    for (n = 0; n < 1450; n++) begin
      if (n == 480) begin
        send_idle_pct = 57;
        recv_idle_pct = 11;
      end else if (n == 960) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_item();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
